@@ src/oaht_pkg.sv @@
// Shared constants, operation codes and controller/datapath bundles
// for the open-addressing hash table. No dependencies.
package oaht_pkg;

    // Slot count; must be a power of two (home slot is the low hash bits).
    localparam int SLOTS  = 64;
    localparam int IDX_W  = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int KEY_W  = 32;
    localparam int HASH_W = 32;
    localparam int VAL_W  = 64;
    localparam int LIM_W  = 6;

    localparam logic [LIM_W-1:0] LIM_RESET = 6'd48;

    typedef enum logic [1:0] {
        OP_SET    = 2'd0,
        OP_GET    = 2'd1,
        OP_REMOVE = 2'd2,
        OP_CLEAR  = 2'd3
    } t_op;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;    // capture the input item, start the probe at home
        logic read;    // read key and value memories at the probe slot
        logic check;   // evaluate the probe slot, advance the probe
        logic commit;  // apply the update and load the result register
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_clear;   // captured item is a clear
        logic probe_end;  // the slot under check ends the probe
        logic out_free;   // result register can take a new result
    } t_dp_sts;

endpackage

@@ src/oaht_if.sv @@
// Valid/ready channel interfaces for hash table operations and results.
// Depends on oaht_pkg for field widths.
interface oaht_in_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  op;
    logic [oaht_pkg::KEY_W-1:0]  key_id;
    logic [oaht_pkg::HASH_W-1:0] key_hash;
    logic [oaht_pkg::VAL_W-1:0]  write_value;

    modport source (output valid, op, key_id, key_hash, write_value, input ready);
    modport sink   (input valid, op, key_id, key_hash, write_value, output ready);
endinterface

interface oaht_out_if;
    logic                       valid;
    logic                       ready;
    logic                       flag;
    logic [oaht_pkg::VAL_W-1:0] read_value;
    logic                       table_full;

    modport source (output valid, flag, read_value, table_full, input ready);
    modport sink   (input valid, flag, read_value, table_full, output ready);
endinterface

@@ src/oaht_ctrl.sv @@
// Controller state machine: sequences load, slot reads, probe checks and commit.
// Depends on oaht_pkg for command and status bundles.
module oaht_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  oaht_pkg::t_dp_sts i_sts,
    output oaht_pkg::t_dp_cmd o_cmd
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_READ   = 4'b0010,
        ST_CHECK  = 4'b0100,
        ST_COMMIT = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_in_ready = (r_state == ST_IDLE);

    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_READ;
                end
            end
            ST_READ: begin
                // clear needs no probe
                if (i_sts.is_clear) begin
                    n_state = ST_COMMIT;
                end else begin
                    o_cmd.read = 1'b1;
                    n_state    = ST_CHECK;
                end
            end
            ST_CHECK: begin
                o_cmd.check = 1'b1;
                n_state     = i_sts.probe_end ? ST_COMMIT : ST_READ;
            end
            ST_COMMIT: begin
                // hold until the result register frees up
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ src/oaht_dp.sv @@
// Datapath: slot status flops, key and value memories, probe registers,
// occupancy count, load limit register and result register. Uses oaht_pkg.
module oaht_dp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  oaht_pkg::t_dp_cmd           i_cmd,
    output oaht_pkg::t_dp_sts           o_sts,
    input  logic [1:0]                  i_op,
    input  logic [oaht_pkg::KEY_W-1:0]  i_key_id,
    input  logic [oaht_pkg::HASH_W-1:0] i_key_hash,
    input  logic [oaht_pkg::VAL_W-1:0]  i_write_value,
    input  logic                        i_cfg_we,
    input  logic [oaht_pkg::LIM_W-1:0]  i_cfg_wdata,
    input  logic                        i_out_ready,
    output logic                        o_out_valid,
    output logic                        o_flag,
    output logic [oaht_pkg::VAL_W-1:0]  o_read_value,
    output logic                        o_table_full
);

    // Slot memories
    logic [oaht_pkg::KEY_W-1:0] r_key_mem [oaht_pkg::SLOTS];
    logic [oaht_pkg::VAL_W-1:0] r_val_mem [oaht_pkg::SLOTS];
    logic [oaht_pkg::KEY_W-1:0] r_key_q;
    logic [oaht_pkg::VAL_W-1:0] r_val_q;

    // Slot status: neither bit set means empty
    logic [oaht_pkg::SLOTS-1:0] r_used;
    logic [oaht_pkg::SLOTS-1:0] r_tomb;
    logic [oaht_pkg::CNT_W-1:0] r_count;
    logic [oaht_pkg::LIM_W-1:0] r_load_limit;

    // Captured item and probe state
    oaht_pkg::t_op              r_op;
    logic [oaht_pkg::KEY_W-1:0] r_key;
    logic [oaht_pkg::VAL_W-1:0] r_val;
    logic [oaht_pkg::IDX_W-1:0] r_idx;
    logic [oaht_pkg::IDX_W-1:0] r_steps;
    logic                       r_tomb_seen;
    logic [oaht_pkg::IDX_W-1:0] r_tomb_idx;
    logic                       r_found;
    logic                       r_have;
    logic [oaht_pkg::IDX_W-1:0] r_where;

    // Result register
    logic                       r_out_valid;
    logic                       r_flag;
    logic [oaht_pkg::VAL_W-1:0] r_rd;
    logic                       r_full;

    // Probe check
    logic                       cur_used;
    logic                       cur_tomb;
    logic                       cur_empty;
    logic                       hit;
    logic                       last;
    logic                       n_tomb_seen;
    logic [oaht_pkg::IDX_W-1:0] n_tomb_idx;

    // Commit decisions
    logic                       wh_tomb;
    logic [oaht_pkg::CNT_W:0]   cnt_inc;
    logic                       lim_hit;
    logic                       wr_key;
    logic                       wr_val;
    logic                       mark_used;
    logic                       mark_tomb;
    logic                       do_clear;
    logic                       inc_count;
    logic                       n_flag;
    logic [oaht_pkg::VAL_W-1:0] n_rd;
    logic                       n_full;

    assign cur_used    = r_used[r_idx];
    assign cur_tomb    = r_tomb[r_idx];
    assign cur_empty   = !cur_used && !cur_tomb;
    assign hit         = cur_used && (r_key_q == r_key);
    assign last        = (r_steps == oaht_pkg::IDX_W'(oaht_pkg::SLOTS - 1));
    assign n_tomb_seen = r_tomb_seen || cur_tomb;
    assign n_tomb_idx  = r_tomb_seen ? r_tomb_idx : r_idx;

    assign o_sts.is_clear  = (r_op == oaht_pkg::OP_CLEAR);
    assign o_sts.probe_end = cur_empty || hit || last;
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    assign wh_tomb = r_tomb[r_where];
    assign cnt_inc = {1'b0, r_count} + (oaht_pkg::CNT_W + 1)'(1);
    assign lim_hit = 32'(cnt_inc) > 32'(r_load_limit);

    always_comb begin
        wr_key    = 1'b0;
        wr_val    = 1'b0;
        mark_used = 1'b0;
        mark_tomb = 1'b0;
        do_clear  = 1'b0;
        inc_count = 1'b0;
        n_flag    = 1'b0;
        n_rd      = '0;
        n_full    = 1'b0;
        unique case (r_op)
            oaht_pkg::OP_SET: begin
                if (r_found) begin
                    wr_val = 1'b1;
                end else if (!r_have) begin
                    n_full = 1'b1;
                end else if (wh_tomb) begin
                    // reuse the tombstone, count stays
                    wr_key    = 1'b1;
                    wr_val    = 1'b1;
                    mark_used = 1'b1;
                    n_flag    = 1'b1;
                end else if (lim_hit) begin
                    n_full = 1'b1;
                end else begin
                    wr_key    = 1'b1;
                    wr_val    = 1'b1;
                    mark_used = 1'b1;
                    inc_count = 1'b1;
                    n_flag    = 1'b1;
                end
            end
            oaht_pkg::OP_GET: begin
                if (r_found) begin
                    n_flag = 1'b1;
                    n_rd   = r_val_q;
                end
            end
            oaht_pkg::OP_REMOVE: begin
                if (r_found) begin
                    mark_tomb = 1'b1;
                    n_flag    = 1'b1;
                end
            end
            oaht_pkg::OP_CLEAR: begin
                do_clear = 1'b1;
            end
            default: ;
        endcase
    end

    // Key and value memories: one write and one registered read each
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && wr_key) begin
            r_key_mem[r_where] <= r_key;
        end
        if (i_cmd.read) begin
            r_key_q <= r_key_mem[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && wr_val) begin
            r_val_mem[r_where] <= r_val;
        end
        if (i_cmd.read) begin
            r_val_q <= r_val_mem[r_idx];
        end
    end

    // Probe registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op        <= oaht_pkg::t_op'(i_op);
            r_key       <= i_key_id;
            r_val       <= i_write_value;
            r_idx       <= i_key_hash[oaht_pkg::IDX_W-1:0];
            r_steps     <= '0;
            r_tomb_seen <= 1'b0;
            r_tomb_idx  <= '0;
            r_found     <= 1'b0;
            r_have      <= 1'b0;
            r_where     <= '0;
        end else if (i_cmd.check) begin
            r_tomb_seen <= n_tomb_seen;
            r_tomb_idx  <= n_tomb_idx;
            r_idx       <= r_idx + oaht_pkg::IDX_W'(1);
            r_steps     <= r_steps + oaht_pkg::IDX_W'(1);
            if (hit) begin
                r_found <= 1'b1;
                r_have  <= 1'b1;
                r_where <= r_idx;
            end else if (cur_empty) begin
                r_have  <= 1'b1;
                r_where <= n_tomb_idx;
            end else if (last) begin
                // wrapped all the way: fall back to the first tombstone
                r_have  <= n_tomb_seen;
                r_where <= n_tomb_idx;
            end
        end
    end

    // Slot status, occupancy count and load limit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used       <= '0;
            r_tomb       <= '0;
            r_count      <= '0;
            r_load_limit <= oaht_pkg::LIM_RESET;
        end else begin
            if (i_cfg_we) begin
                r_load_limit <= i_cfg_wdata;
            end
            if (i_cmd.commit) begin
                if (do_clear) begin
                    r_used  <= '0;
                    r_tomb  <= '0;
                    r_count <= '0;
                end else begin
                    if (mark_used) begin
                        r_used[r_where] <= 1'b1;
                        r_tomb[r_where] <= 1'b0;
                    end
                    if (mark_tomb) begin
                        r_used[r_where] <= 1'b0;
                        r_tomb[r_where] <= 1'b1;
                    end
                    if (inc_count) begin
                        r_count <= cnt_inc[oaht_pkg::CNT_W-1:0];
                    end
                end
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_flag <= n_flag;
            r_rd   <= n_rd;
            r_full <= n_full;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_flag       = r_flag;
    assign o_read_value = r_rd;
    assign o_table_full = r_full;

endmodule

@@ src/open_addressing_hash_table.sv @@
// Per item: load, then a registered key/value memory read and a probe check for
// each slot probed (1 to 64), then a commit that loads the result register; a
// clear skips the reads and checks. Commit waits while the result register holds
// an untaken result; a new item is taken only after the commit, one at a time.
// Reset: synchronous, active low; all slots empty, count 0, load limit 48,
// no clearing pass. Top level: controller plus datapath; uses oaht_pkg, oaht_if.
module open_addressing_hash_table (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    oaht_in_if.sink                    i_in,
    oaht_out_if.source                 o_out,
    input  logic                       i_cfg_we,
    input  logic [oaht_pkg::LIM_W-1:0] i_cfg_wdata
);

    oaht_pkg::t_dp_cmd cmd;
    oaht_pkg::t_dp_sts sts;

    oaht_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    oaht_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_op          (i_in.op),
        .i_key_id      (i_in.key_id),
        .i_key_hash    (i_in.key_hash),
        .i_write_value (i_in.write_value),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_out_ready   (o_out.ready),
        .o_out_valid   (o_out.valid),
        .o_flag        (o_out.flag),
        .o_read_value  (o_out.read_value),
        .o_table_full  (o_out.table_full)
    );

`ifndef SYNTHESIS
    // one item at a time: after a transfer the input side goes busy
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready |=> !i_in.ready)
        else $error("input ready right after a transfer");

    a_full_not_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !(o_out.flag && o_out.table_full))
        else $error("result both flagged and refused");

    a_read_only_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && (o_out.read_value != '0) |-> o_out.flag)
        else $error("nonzero read value without a hit");
`endif

endmodule

@@ tb/sv/tb.sv @@
// Self-checking bench for open_addressing_hash_table: directed and random set/get/remove/clear
// traffic checked against a slot-level model of the probing table.
// Depends on oaht_pkg and the oaht_in_if / oaht_out_if interfaces.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import oaht_pkg::*;

    localparam int RUN_LIMIT    = 800_000;
    localparam int DRAIN_CYCLES = 140;
    localparam int SHOWN_ERRORS = 10;
    localparam int POOL_MAX     = 64;

    typedef enum logic [1:0] {
        SLOT_EMPTY = 2'd0,
        SLOT_USED  = 2'd1,
        SLOT_TOMB  = 2'd2
    } t_slot_state;

    typedef struct packed {
        logic             flag;
        logic [VAL_W-1:0] read_value;
        logic             table_full;
    } t_result;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [LIM_W-1:0] i_cfg_wdata;

    oaht_in_if  in_if ();
    oaht_out_if out_if ();

    open_addressing_hash_table i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_if),
        .o_out       (out_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // Table model
    logic [KEY_W-1:0] model_key   [SLOTS];
    logic [VAL_W-1:0] model_value [SLOTS];
    t_slot_state      model_state [SLOTS];
    logic [6:0]       model_count;
    logic [LIM_W-1:0] model_limit;

    t_result pending_results[$];
    int      mismatches;
    int      cycle_count;
    bit      idle_en;
    int      hold_request;
    int      hold_left;

    // Key pool for random traffic: each key keeps one hash
    logic [KEY_W-1:0]  pool_key  [POOL_MAX];
    logic [HASH_W-1:0] pool_hash [POOL_MAX];
    int                pool_n;

    function automatic t_result table_apply(t_op op, logic [KEY_W-1:0] key,
                                            logic [HASH_W-1:0] hash,
                                            logic [VAL_W-1:0] val);
        t_result          res;
        logic [IDX_W-1:0] idx;
        logic [IDX_W-1:0] tomb;
        logic [IDX_W-1:0] where;
        bit               tomb_seen;
        bit               found;
        bit               have;
        bit               done;
        res       = '0;
        tomb      = '0;
        where     = '0;
        tomb_seen = 0;
        found     = 0;
        have      = 0;
        done      = 0;
        if (op == OP_CLEAR) begin
            foreach (model_state[i]) model_state[i] = SLOT_EMPTY;
            model_count = '0;
            return res;
        end
        idx = hash[IDX_W-1:0];
        for (int i = 0; i < SLOTS; i++) begin
            if (!done) begin
                if (model_state[idx] == SLOT_EMPTY) begin
                    where = tomb_seen ? tomb : idx;
                    have  = 1;
                    done  = 1;
                end else if (model_state[idx] == SLOT_TOMB) begin
                    if (!tomb_seen) begin
                        tomb      = idx;
                        tomb_seen = 1;
                    end
                end else if (model_key[idx] == key) begin
                    where = idx;
                    have  = 1;
                    found = 1;
                    done  = 1;
                end
                idx = idx + 1'b1;
            end
        end
        // Probe wrapped all the way: only a tombstone can take the key
        if (!done) begin
            where = tomb;
            have  = tomb_seen;
        end
        case (op)
            OP_SET: begin
                if (found) begin
                    model_value[where] = val;
                end else if (!have) begin
                    res.table_full = 1;
                end else if (model_state[where] == SLOT_TOMB) begin
                    model_state[where] = SLOT_USED;
                    model_key[where]   = key;
                    model_value[where] = val;
                    res.flag           = 1;
                end else if (int'(model_count) + 1 > int'(model_limit)) begin
                    res.table_full = 1;
                end else begin
                    model_count        = model_count + 1'b1;
                    model_state[where] = SLOT_USED;
                    model_key[where]   = key;
                    model_value[where] = val;
                    res.flag           = 1;
                end
            end
            OP_GET: begin
                if (found) begin
                    res.flag       = 1;
                    res.read_value = model_value[where];
                end
            end
            default: begin
                if (found) begin
                    model_state[where] = SLOT_TOMB;
                    res.flag           = 1;
                end
            end
        endcase
        return res;
    endfunction

    function void report_mismatch(string field, logic [VAL_W-1:0] want, logic [VAL_W-1:0] got);
        mismatches++;
        if (mismatches <= SHOWN_ERRORS)
            $display("ERROR cycle %0d: %s expected %h got %h", cycle_count, field, want, got);
    endfunction

    // Home slots of the pool fall in [base, base+spread) modulo the slot count
    function void make_pool(int n, int base, int spread);
        pool_n = n;
        for (int i = 0; i < n; i++) begin
            pool_key[i]  = (i == 0 && $urandom_range(3) == 0) ? '0 : KEY_W'($urandom);
            pool_hash[i] = HASH_W'($urandom);
            pool_hash[i][IDX_W-1:0] = IDX_W'((base + $urandom_range(spread - 1)) % SLOTS);
        end
    endfunction

    // Clock and run limit
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < RUN_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Result side: random stalls plus requested hold-offs
    initial begin
        out_if.ready <= 1'b0;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_request != 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                out_if.ready <= 1'b0;
                hold_left--;
            end else begin
                out_if.ready <= !(idle_en && $urandom_range(99) < 19);
            end
        end
    end

    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unrequested result, read_value", '0, out_if.read_value);
            end else begin
                want = pending_results.pop_front();
                if (want.flag !== out_if.flag)
                    report_mismatch("flag", VAL_W'(want.flag), VAL_W'(out_if.flag));
                if (want.read_value !== out_if.read_value)
                    report_mismatch("read_value", want.read_value, out_if.read_value);
                if (want.table_full !== out_if.table_full)
                    report_mismatch("table_full", VAL_W'(want.table_full),
                                    VAL_W'(out_if.table_full));
            end
        end
    end

    task automatic issue_op(t_op op, logic [KEY_W-1:0] key, logic [HASH_W-1:0] hash,
                            logic [VAL_W-1:0] val);
        int gap;
        if (idle_en && $urandom_range(99) < 19) begin
            in_if.valid <= 1'b0;
            gap = $urandom_range(1, 4);
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid       <= 1'b1;
        in_if.op          <= op;
        in_if.key_id      <= key;
        in_if.key_hash    <= hash;
        in_if.write_value <= val;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        pending_results.push_back(table_apply(op, key, hash, val));
    endtask

    // Drop valid and wait until every result has been taken
    task automatic settle();
        in_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic write_limit(logic [LIM_W-1:0] limit);
        settle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= limit;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        model_limit = limit;
    endtask

    task automatic random_ops(int n);
        int                r;
        int                k;
        t_op               op;
        logic [KEY_W-1:0]  key;
        logic [HASH_W-1:0] hash;
        for (int i = 0; i < n; i++) begin
            r    = $urandom_range(99);
            k    = $urandom_range(pool_n - 1);
            key  = pool_key[k];
            hash = pool_hash[k];
            if (r < 44)      op = OP_SET;
            else if (r < 74) op = OP_GET;
            else if (r < 97) op = OP_REMOVE;
            else             op = OP_CLEAR;
            // Occasional noise: any op on a stray key/hash
            if ($urandom_range(99) < 5) begin
                op   = t_op'($urandom_range(3));
                key  = KEY_W'($urandom);
                hash = HASH_W'($urandom);
            end
            issue_op(op, key, hash, {32'($urandom), 32'($urandom)});
        end
    endtask

    // Runs at the reset limit; keys homed on the last slot force wrap-around
    task automatic test_basic_ops();
        logic [KEY_W-1:0]  key_a;
        logic [KEY_W-1:0]  key_c;
        logic [KEY_W-1:0]  key_d;
        logic [KEY_W-1:0]  key_e;
        logic [HASH_W-1:0] home_last;
        key_a     = '1;
        key_c     = 32'h8000_0001;
        key_d     = 32'h5A5A_A5A5;
        key_e     = 32'h0000_0100;
        home_last = '1;
        issue_op(OP_GET,    key_a, home_last, '1);
        issue_op(OP_REMOVE, key_a, home_last, '1);
        issue_op(OP_SET,    key_a, home_last, '1);
        issue_op(OP_SET,    key_a, home_last, 64'h0123_4567_89AB_CDEF);
        issue_op(OP_GET,    key_a, home_last, '0);
        issue_op(OP_SET,    '0, 32'hFFFF_FFC0, '0);
        issue_op(OP_GET,    '0, 32'hFFFF_FFC0, '1);
        issue_op(OP_SET,    key_c, 32'h1234_567F, {32'($urandom), 32'($urandom)});
        issue_op(OP_SET,    key_d, 32'h0000_003F, {32'($urandom), 32'($urandom)});
        issue_op(OP_REMOVE, key_c, 32'h1234_567F, '0);
        issue_op(OP_GET,    key_d, 32'h0000_003F, '0);
        issue_op(OP_GET,    key_c, 32'h1234_567F, '0);
        issue_op(OP_REMOVE, key_c, 32'h1234_567F, '0);
        // New key on the same home slot lands in the tombstone
        issue_op(OP_SET,    key_e, 32'hFFFF_FFFF, {32'($urandom), 32'($urandom)});
        issue_op(OP_GET,    key_e, 32'hFFFF_FFFF, '0);
        issue_op(OP_CLEAR,  KEY_W'($urandom), HASH_W'($urandom), '1);
        issue_op(OP_GET,    key_a, home_last, '0);
        issue_op(OP_SET,    key_a, home_last, {32'($urandom), 32'($urandom)});
    endtask

    task automatic test_small_limits();
        logic [KEY_W-1:0] key_b;
        key_b = 32'h0BAD_F00D;
        write_limit(6'd1);
        issue_op(OP_SET,    key_b, 32'h0000_0005, '1);
        issue_op(OP_SET,    '1, '1, 64'hFEDC_BA98_7654_3210);
        issue_op(OP_REMOVE, '1, '1, '0);
        // Tombstone reuse still works at the limit
        issue_op(OP_SET,    key_b, 32'hABCD_EFFF, {32'($urandom), 32'($urandom)});
        issue_op(OP_GET,    key_b, 32'hABCD_EFFF, '0);
        write_limit(6'd0);
        issue_op(OP_CLEAR,  '0, '0, '0);
        issue_op(OP_SET,    key_b, 32'hABCD_EFFF, '1);
        issue_op(OP_GET,    key_b, 32'hABCD_EFFF, '0);
    endtask

    task automatic test_fill_and_wrap();
        int k;
        write_limit('1);
        issue_op(OP_CLEAR, '0, '0, '0);
        make_pool(SLOTS - 1, SLOTS - 4, 4);
        for (int i = 0; i < pool_n; i++)
            issue_op(OP_SET, pool_key[i], pool_hash[i], {32'($urandom), 32'($urandom)});
        issue_op(OP_SET, 32'h7777_0000, 32'h0000_003E, '1);
        for (int i = 0; i < 12; i++) begin
            k = $urandom_range(pool_n - 1);
            issue_op(OP_GET, pool_key[k], pool_hash[k], '0);
        end
        for (int i = 0; i < 4; i++) begin
            k = $urandom_range(pool_n - 1);
            issue_op(OP_REMOVE, pool_key[k], pool_hash[k], '0);
        end
        issue_op(OP_SET, 32'h7777_0001, 32'h0000_003D, {32'($urandom), 32'($urandom)});
        issue_op(OP_GET, 32'h7777_0001, 32'h0000_003D, '0);
    endtask

    task automatic test_random_traffic();
        write_limit(LIM_RESET);
        make_pool(24, $urandom_range(SLOTS - 1), SLOTS);
        random_ops(250);
        write_limit('1);
        make_pool(48, $urandom_range(SLOTS - 1), 12);
        random_ops(250);
        write_limit(6'd1);
        make_pool(6, 0, SLOTS);
        random_ops(100);
        write_limit(6'd0);
        random_ops(60);
        write_limit(LIM_W'($urandom_range(2, 62)));
        make_pool(30, $urandom_range(SLOTS - 1), SLOTS);
        random_ops(230);
    endtask

    // Hold results off so the block backs up while items keep coming
    task automatic test_backpressure();
        make_pool(16, $urandom_range(SLOTS - 1), 8);
        hold_request = 300;
        random_ops(40);
    endtask

    task automatic test_no_idle();
        write_limit(6'd32);
        idle_en = 1'b0;
        make_pool(20, $urandom_range(SLOTS - 1), 16);
        random_ops(200);
        idle_en = 1'b1;
    endtask

    initial begin
        mismatches   = 0;
        idle_en      = 1'b1;
        hold_request = 0;
        pool_n       = 1;
        foreach (model_state[i]) begin
            model_state[i] = SLOT_EMPTY;
            model_key[i]   = '0;
            model_value[i] = '0;
        end
        model_count = '0;
        model_limit = LIM_RESET;

        i_rst_n           <= 1'b0;
        i_cfg_we          <= 1'b0;
        i_cfg_wdata       <= '0;
        in_if.valid       <= 1'b0;
        in_if.op          <= OP_SET;
        in_if.key_id      <= '0;
        in_if.key_hash    <= '0;
        in_if.write_value <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_basic_ops();
        test_small_limits();
        test_fill_and_wrap();
        test_random_traffic();
        test_backpressure();
        test_no_idle();

        settle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

@@ files.f @@
src/oaht_pkg.sv
src/oaht_if.sv
src/oaht_ctrl.sv
src/oaht_dp.sv
src/open_addressing_hash_table.sv
tb/sv/tb.sv
